FILE: sv/rmf_pkg.sv
// ----------------------------------------------------------------------------
// Running median filter package
// Shared widths, register indexes, reset values and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int VALUE_W      = 8;
   localparam int MEDIAN_W     = 9;
   localparam int COUNT_OUT_W  = 9;
   localparam int CSR_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CAPACITY_DEF = 256;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_LIMIT = 2'd1;

   localparam logic [VALUE_W-1:0] LOW_LIMIT_RESET  = 8'd0;
   localparam logic [VALUE_W-1:0] HIGH_LIMIT_RESET = 8'd100;

   // Address sources for the store's main read port.
   localparam logic [1:0] RD_TAIL = 2'd0;
   localparam logic [1:0] RD_NEXT = 2'd1;
   localparam logic [1:0] RD_MED  = 2'd2;

   typedef struct packed {
      logic       capture;   // take the sample, start at the tail
      logic       rd_en;     // issue a read on the main port
      logic [1:0] rd_sel;    // address source of that read
      logic       shift;     // move the entry read one place up
      logic       place;     // write the sample into the hole
      logic       out_load;  // load the result register
   } cmd_type;

   typedef struct packed {
      logic in_range;    // incoming sample lies within the limits
      logic full;        // store holds its capacity
      logic count_zero;  // store is empty
      logic pos_one;     // hole is at entry one
      logic greater;     // entry read is larger than the sample
      logic rsp_busy;    // result register holds a word that is not taken
   } sts_type;

endpackage

FILE: sv/rmf_controller.sv
// ----------------------------------------------------------------------------
// Running median filter controller
// Sequences capture, the insertion walk, the median read and the result load.
// ----------------------------------------------------------------------------
module rmf_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmf_pkg::sts_type sts,
   output rmf_pkg::cmd_type cmd
);
   import rmf_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SHIFT   = 3'd1;
   localparam logic [2:0] ST_PLACE   = 3'd2;
   localparam logic [2:0] ST_MEDREAD = 3'd3;
   localparam logic [2:0] ST_OUT     = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_TAIL;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.in_range) begin
               cmd.capture = 1'b1;
               if (sts.full) begin
                  state_in = ST_MEDREAD;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_TAIL;
                  state_in   = sts.count_zero ? ST_PLACE : ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (sts.greater) begin
               cmd.shift = 1'b1;
               if (sts.pos_one) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_MEDREAD;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_MEDREAD;
         end
         ST_MEDREAD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_MED;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/rmf_datapath.sv
// ----------------------------------------------------------------------------
// Running median filter datapath
// Limit registers, the sorted store, the insertion pointer and the result
// register.
// ----------------------------------------------------------------------------
module rmf_datapath #(
   parameter int CAPACITY = rmf_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rmf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rmf_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic signed [rmf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                              rsp_ready,
   input  rmf_pkg::cmd_type                  cmd,
   output rmf_pkg::sts_type                  sts,
   output logic                              rsp_valid,
   output logic [rmf_pkg::MEDIAN_W-1:0]      rsp_median_half_units,
   output logic [rmf_pkg::COUNT_OUT_W-1:0]   rsp_stored_count,
   output logic                              rsp_dropped
);
   import rmf_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [VALUE_W-1:0] low_limit_ff;
   logic [VALUE_W-1:0] high_limit_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      pos_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               dropped_ff;
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;
   logic               rsp_valid_ff;
   logic [MEDIAN_W-1:0]    rsp_median_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   rsp_dropped_ff;

   logic [VALUE_W-1:0] sorted_mem [CAPACITY];

   logic [VALUE_W-1:0] sample_low;
   logic               sample_fits;
   logic [CW-1:0]      mid;
   logic [CW-1:0]      rd_addr;
   logic               wr_en;
   logic [VALUE_W-1:0] wr_data;
   logic [MEDIAN_W-1:0] median_sum;
   logic [CW+COUNT_OUT_W-1:0] count_wide;

   // A sample is usable only when it is non-negative and fits in a byte.
   assign sample_low  = req_sample[VALUE_W-1:0];
   assign sample_fits = !req_sample[SAMPLE_W-1] && (req_sample[SAMPLE_W-2:VALUE_W] == '0);

   assign sts.in_range   = sample_fits && (sample_low >= low_limit_ff)
                           && (sample_low <= high_limit_ff);
   assign sts.full       = (count_ff == CW'(CAPACITY));
   assign sts.count_zero = (count_ff == '0);
   assign sts.pos_one    = (pos_ff == CW'(1));
   assign sts.greater    = (rd_a_ff > value_ff);
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign mid = count_ff >> 1;

   always_comb begin
      case (cmd.rd_sel)
         RD_TAIL: rd_addr = count_ff - CW'(1);
         RD_NEXT: rd_addr = pos_ff - CW'(2);
         RD_MED:  rd_addr = count_ff[0] ? mid : mid - CW'(1);
         default: rd_addr = count_ff - CW'(1);
      endcase
   end

   assign wr_en   = cmd.shift || cmd.place;
   assign wr_data = cmd.shift ? rd_a_ff : value_ff;

   // Odd count reads the middle entry on both ports, so the sum doubles it.
   assign median_sum = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sorted_mem[pos_ff[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= sorted_mem[rd_addr[AW-1:0]];
      end
      rd_b_ff <= sorted_mem[mid[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff   <= sample_low;
         dropped_ff <= sts.full;
      end
      if (cmd.out_load) begin
         rsp_median_ff  <= median_sum;
         rsp_count_ff   <= count_wide[COUNT_OUT_W-1:0];
         rsp_dropped_ff <= dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= LOW_LIMIT_RESET;
         high_limit_ff <= HIGH_LIMIT_RESET;
         count_ff      <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_LOW_LIMIT:  low_limit_ff  <= csr_write_data;
               REG_HIGH_LIMIT: high_limit_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (cmd.capture) begin
            pos_ff <= count_ff;
         end else if (cmd.shift) begin
            pos_ff <= pos_ff - CW'(1);
         end
         if (cmd.place) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_median_half_units = rsp_median_ff;
   assign rsp_stored_count      = rsp_count_ff;
   assign rsp_dropped           = rsp_dropped_ff;

endmodule

FILE: sv/running_median_filter.sv
// An in-range word is captured, each stored entry larger than it moves one place up, the
// word fills the hole, and the median is read and loaded into the result register; a full
// store drops the word and only reads and loads the median. The walk uses the store's
// single write port, one entry a cycle. A new word is taken only after the last result is
// loaded; an out-of-range word is discarded. Reset (synchronous, active high) empties the
// store, restores the limits to 0 and 100 and clears rsp_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Running median filter
// Keeps accepted samples in a sorted store and returns the running median,
// in half units, for every sample that falls within the configured limits.
// ----------------------------------------------------------------------------
module running_median_filter #(
   parameter int CAPACITY = rmf_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rmf_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rmf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rmf_pkg::MEDIAN_W-1:0]        rsp_median_half_units,
   output logic [rmf_pkg::COUNT_OUT_W-1:0]     rsp_stored_count,
   output logic                                rsp_dropped
);
   import rmf_pkg::*;

   // The stored count seen on the result port is the low nine bits.
   localparam logic [COUNT_OUT_W-1:0] CAP_REPORTED = COUNT_OUT_W'(CAPACITY);

   cmd_type cmd;
   sts_type sts;

   // The controller only walks states; every register holding sample data,
   // the limits and the store itself sit in the datapath. A word is taken
   // only while the controller is idle, but a finished result may still be
   // waiting in the output register at that time, so a slow consumer does
   // not stall the start of the next insertion.
   rmf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The store is a single memory with one write port and two registered
   // read ports. Insertion starts at the tail and moves each larger entry
   // one place up per cycle until the hole reaches the sample's place; the
   // median then comes from the one or two middle entries.
   rmf_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_sample            (req_sample),
      .rsp_ready             (rsp_ready),
      .cmd                   (cmd),
      .sts                   (sts),
      .rsp_valid             (rsp_valid),
      .rsp_median_half_units (rsp_median_half_units),
      .rsp_stored_count      (rsp_stored_count),
      .rsp_dropped           (rsp_dropped)
   );

   // A dropped result can only come from a full store.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_stored_count == CAP_REPORTED))
      else $error("dropped result with a store that is not full");

   // Nothing is ever written into a full store.
   assert property (@(posedge clock) disable iff (reset)
      (sts.full && !cmd.capture) |-> !(cmd.place || cmd.shift))
      else $error("write into a full store");

   // An out-of-range word is discarded silently; the block stays ready.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !sts.in_range) |=> req_ready)
      else $error("out-of-range word started an insertion");

   // The result register is never overwritten while its word is pending.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && !rsp_ready))
      else $error("result overwritten before it was taken");

endmodule
